@@ hdl/bfe_pkg.sv @@
`default_nettype none

package bfe_pkg;

    localparam logic [7:0] ESC_BYTE  = 8'h1A;
    localparam logic [7:0] TYPE_BASE = 8'h31;
    localparam int         TS_BYTES  = 6;
    localparam int         PAY_BITS  = 112;

    typedef struct packed {
        logic [1:0]  frame_type;
        logic [47:0] timestamp;
        logic [7:0]  signal_level;
        logic [63:0] payload_hi;
        logic [47:0] payload_lo;
        logic [3:0]  payload_len;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_beat_t;

    // commands from the sequencer to the byte shifter
    typedef struct packed {
        logic load;
        logic shift;
    } bfe_ctrl_t;

    // head byte of the shifter and its escape compare
    typedef struct packed {
        logic [7:0] head;
        logic       is_esc;
    } bfe_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ESC  = 5'b00010,
        ST_TYPE = 5'b00100,
        ST_BODY = 5'b01000,
        ST_DUP  = 5'b10000
    } bfe_state_t;

endpackage

`default_nettype wire

@@ hdl/bfe_shift_unit.sv @@
`default_nettype none

module bfe_shift_unit
    import bfe_pkg::*;
#(
    parameter int BYTES = 21
) (
    input  wire logic               clk,
    input  wire bfe_ctrl_t          ctrl,
    input  wire logic [BYTES*8-1:0] load_data,
    output bfe_stat_t               stat
);

    logic [BYTES*8-1:0] buf_reg;
    logic [BYTES*8-1:0] buf_next;

    always_comb
    begin
        buf_next = buf_reg;
        if (ctrl.load)
        begin
            buf_next = load_data;
        end
        else if (ctrl.shift)
        begin
            buf_next = {buf_reg[BYTES*8-9:0], 8'h00};
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign stat = '{head:   buf_reg[BYTES*8-1 -: 8],
                    is_esc: (buf_reg[BYTES*8-1 -: 8] == ESC_BYTE)};

endmodule

`default_nettype wire

@@ hdl/beast_frame_escape_encoder_core.sv @@
// an accepted frame beat moves the sequencer to ST_ESC, which registers the escape
// byte when the output slot is free; throughput: one output byte per cycle while
// out_ready stays high; a frame gives 9 + saturated payload_len + (number of 0x1A
// body bytes) bytes, and the single byte shifter takes a new frame only in idle
// reset: rst_n low clears the sequencer to idle and empties the output register
`default_nettype none

module beast_frame_escape_encoder_core
    import bfe_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = 14
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_beat_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_beat_t     out_data
);

    localparam int BUF_BYTES = TS_BYTES + 1 + MAX_PAYLOAD_BYTES;
    localparam int CNT_W     = $clog2(BUF_BYTES + 1);

    bfe_state_t state_reg;
    bfe_state_t state_next;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] rem_next;
    logic [1:0] type_reg;
    logic [1:0] type_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_beat_t  out_data_reg;
    out_beat_t  out_data_next;

    bfe_ctrl_t  ctrl;
    bfe_stat_t  stat;
    logic [3:0] plen_sat;
    logic [PAY_BITS-1:0] pay_all;
    logic [BUF_BYTES*8-1:0] load_data;
    logic       slot_free;
    logic       in_fire;
    logic       rem_one;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign rem_one   = (rem_reg == CNT_W'(1));

    assign plen_sat = (in_data.payload_len > 4'(MAX_PAYLOAD_BYTES)) ?
                      4'(MAX_PAYLOAD_BYTES) : in_data.payload_len;
    assign pay_all   = {in_data.payload_hi, in_data.payload_lo};
    assign load_data = {in_data.timestamp, in_data.signal_level,
                        pay_all[PAY_BITS-1 -: MAX_PAYLOAD_BYTES*8]};

    bfe_shift_unit #(
        .BYTES(BUF_BYTES)
    ) u_shift (
        .clk       (clk),
        .ctrl      (ctrl),
        .load_data (load_data),
        .stat      (stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        type_next      = type_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl.load      = 1'b0;
        ctrl.shift     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ctrl.load  = 1'b1;
                    rem_next   = CNT_W'(TS_BYTES + 1) + CNT_W'(plen_sat);
                    type_next  = in_data.frame_type;
                    state_next = ST_ESC;
                end
            end
            ST_ESC:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{out_byte: ESC_BYTE, last_byte: 1'b0};
                    state_next     = ST_TYPE;
                end
            end
            ST_TYPE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{out_byte: TYPE_BASE + {6'b0, type_reg},
                                       last_byte: 1'b0};
                    state_next     = ST_BODY;
                end
            end
            ST_BODY:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (stat.is_esc)
                    begin
                        // first copy of an escape byte, the second one closes it
                        out_data_next = '{out_byte: stat.head, last_byte: 1'b0};
                        state_next    = ST_DUP;
                    end
                    else
                    begin
                        out_data_next = '{out_byte: stat.head, last_byte: rem_one};
                        ctrl.shift    = 1'b1;
                        rem_next      = rem_reg - CNT_W'(1);
                        state_next    = rem_one ? ST_IDLE : ST_BODY;
                    end
                end
            end
            ST_DUP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{out_byte: ESC_BYTE, last_byte: rem_one};
                    ctrl.shift     = 1'b1;
                    rem_next       = rem_reg - CNT_W'(1);
                    state_next     = rem_one ? ST_IDLE : ST_BODY;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        type_reg     <= type_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ hdl/bfe_checker.sv @@
`default_nettype none

module bfe_checker
    import bfe_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_beat_t out_data
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // a taken frame keeps the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready again right after taking a frame");

    // coming back to idle coincides with the final byte being presented
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid && out_data.last_byte)
        else $error("idle without a pending final byte");

    // after the final beat only a new frame's escape byte may follow
    a_next_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_byte |=>
        !out_valid || (out_data.out_byte == ESC_BYTE && !out_data.last_byte))
        else $error("stray byte after end of frame");

endmodule

bind beast_frame_escape_encoder_core bfe_checker u_bfe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

@@ bench/tb_beast_frame_escape_encoder_core.sv @@
`default_nettype none

module tb_beast_frame_escape_encoder_core;
    import bfe_pkg::*;

    localparam int PAYLOAD_MAX = 14;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;

    // escaped bytes still owed by the encoder, oldest first
    out_beat_t framed_bytes[$];
    int        bad_beats = 0;
    bit        gaps_on = 1'b1;

    beast_frame_escape_encoder_core #(
        .MAX_PAYLOAD_BYTES(PAYLOAD_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    // builds the framed byte run of one frame and queues it
    function automatic void frame_and_escape(input in_beat_t f);
        logic [7:0] body[$];
        out_beat_t  run[$];
        int         plen;
        int         idx;
        plen = (f.payload_len > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(f.payload_len);
        for (int i = 0; i < TS_BYTES; i++)
            body.push_back(f.timestamp[47 - 8 * i -: 8]);
        body.push_back(f.signal_level);
        for (int i = 0; i < plen; i++)
        begin
            if (i < 8)
                body.push_back(f.payload_hi[63 - 8 * i -: 8]);
            else
                body.push_back(f.payload_lo[47 - 8 * (i - 8) -: 8]);
        end
        // header bytes go out as they are
        run.push_back('{out_byte: ESC_BYTE, last_byte: 1'b0});
        run.push_back('{out_byte: TYPE_BASE + 8'(f.frame_type), last_byte: 1'b0});
        foreach (body[i])
        begin
            run.push_back('{out_byte: body[i], last_byte: 1'b0});
            if (body[i] == ESC_BYTE)
                run.push_back('{out_byte: body[i], last_byte: 1'b0});
        end
        idx = run.size() - 1;
        run[idx].last_byte = 1'b1;
        foreach (run[i])
            framed_bytes.push_back(run[i]);
    endfunction

    function automatic in_beat_t make_frame(input logic [1:0] ftype, input logic [47:0] ts,
                                            input logic [7:0] level, input logic [63:0] hi,
                                            input logic [47:0] lo, input logic [3:0] len);
        in_beat_t f;
        f.frame_type   = ftype;
        f.timestamp    = ts;
        f.signal_level = level;
        f.payload_hi   = hi;
        f.payload_lo   = lo;
        f.payload_len  = len;
        return f;
    endfunction

    // bytes lean toward the escape value so doubling shows up often
    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 3) == 0)
            return ESC_BYTE;
        return 8'($urandom);
    endfunction

    function automatic in_beat_t rand_frame();
        in_beat_t f;
        f.frame_type = 2'($urandom_range(0, 3));
        for (int i = 0; i < 6; i++)
            f.timestamp[8 * i +: 8] = rand_byte();
        f.signal_level = rand_byte();
        for (int i = 0; i < 8; i++)
            f.payload_hi[8 * i +: 8] = rand_byte();
        for (int i = 0; i < 6; i++)
            f.payload_lo[8 * i +: 8] = rand_byte();
        f.payload_len = 4'($urandom_range(0, 15));
        return f;
    endfunction

    task automatic send_frame(input in_beat_t f);
        int gap;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        frame_and_escape(f);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (framed_bytes.size() != 0);
    endtask

    task automatic test_frame_types();
        for (int t = 0; t < 4; t++)
            send_frame(make_frame(2'(t), 48'h0102_0304_0506, 8'h80,
                                  64'h1122_3344_5566_7788, 48'h99AA_BBCC_DDEE, 4'd7));
    endtask

    task automatic test_payload_lengths();
        send_frame(make_frame(2'd0, 48'h0, 8'h00, 64'h0, 48'h0, 4'd0));
        send_frame(make_frame(2'd1, 48'hFFFF_FFFF_FFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF,
                              48'hFFFF_FFFF_FFFF, 4'd14));
        // length above the limit saturates
        send_frame(make_frame(2'd2, 48'hA5A5_A5A5_A5A5, 8'h5A, 64'h0123_4567_89AB_CDEF,
                              48'hFEDC_BA98_7654, 4'd15));
        send_frame(make_frame(2'd3, 48'h5A5A_5A5A_5A5A, 8'h01, 64'h8000_0000_0000_0001,
                              48'h8000_0000_0001, 4'd1));
        send_frame(make_frame(2'd0, 48'h0000_0000_0001, 8'h7F, 64'hDEAD_BEEF_CAFE_F00D,
                              48'h1234_5678_9ABC, 4'd8));
        send_frame(make_frame(2'd1, 48'h8000_0000_0000, 8'hFE, 64'hFFFF_FFFF_FFFF_FFFF,
                              48'h0000_0000_0000, 4'd13));
    endtask

    task automatic test_escape_doubling();
        // every body byte an escape: longest possible frame
        send_frame(make_frame(2'd0, {6{ESC_BYTE}}, ESC_BYTE, {8{ESC_BYTE}}, {6{ESC_BYTE}},
                              4'd14));
        // empty payload, doubled level byte carries the end mark
        send_frame(make_frame(2'd1, 48'h0011_2233_4455, ESC_BYTE, {8{ESC_BYTE}},
                              {6{ESC_BYTE}}, 4'd0));
        // escape as the final payload byte
        send_frame(make_frame(2'd2, 48'h1B19_0000_1A00, 8'h1B, 64'h0000_0000_0000_001A,
                              48'h0, 4'd8));
        send_frame(make_frame(2'd3, 48'h0, 8'h00, 64'h0, 48'h0000_0000_001A, 4'd14));
        send_frame(make_frame(2'd0, 48'h1A00_0000_0000, 8'h19, 64'h1A1A_0000_0000_0000,
                              48'h0, 4'd2));
        // type byte values in the body go out as they are, escape values beside them are doubled
        send_frame(make_frame(2'd2, 48'h3131_3233_3434, 8'h1A, 64'h3132_3334_1A1A_1A1A,
                              48'h1A00_1A00_1A00, 4'd12));
    endtask

    task automatic test_random_frames(input int count);
        for (int i = 0; i < count; i++)
            send_frame(rand_frame());
    endtask

    task automatic test_drain_pause();
        test_random_frames(5);
        wait_for_drain();
        test_random_frames(5);
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        test_random_frames(40);
    endtask

    // output side: random stalls and the byte compare
    initial
    begin
        int        stall;
        out_beat_t want;
        stall = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (framed_bytes.size() == 0)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("unexpected beat: byte %h last %b",
                                 out_data.out_byte, out_data.last_byte);
                end
                else
                begin
                    want = framed_bytes.pop_front();
                    if (out_data.out_byte !== want.out_byte ||
                        out_data.last_byte !== want.last_byte)
                    begin
                        bad_beats++;
                        if (bad_beats <= 10)
                            $display("beat mismatch: byte exp %h got %h, last exp %b got %b",
                                     want.out_byte, out_data.out_byte,
                                     want.last_byte, out_data.last_byte);
                    end
                end
            end
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(0, 14);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frame_types();
        test_payload_lengths();
        test_escape_doubling();
        test_random_frames(50);
        test_drain_pause();
        test_random_frames(50);
        test_back_to_back();

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (bad_beats == 0 && framed_bytes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/bfe_pkg.sv
hdl/bfe_shift_unit.sv
hdl/beast_frame_escape_encoder_core.sv
hdl/bfe_checker.sv
bench/tb_beast_frame_escape_encoder_core.sv
